[rtl/core/pol_pkg.sv]
`default_nettype none

package pol_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 1;
    localparam int COUNT_W  = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = KIND_W;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_GET    = 3'd2,
        KIND_LOCATE = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_LOCATE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [COUNT_W-1:0] found;
    } tok_t;

endpackage

`default_nettype wire

[rtl/core/pol_cell.sv]
`default_nettype none

module pol_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF,
    parameter int LEN_W      = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pol_pkg::cmd_t         cmd,
    input  wire logic [LEN_W-1:0]      len,
    input  wire logic [DATA_WIDTH-1:0] val,
    input  wire pol_pkg::tok_t         tok_in,
    input  wire logic [DATA_WIDTH-1:0] carry_in,
    input  wire logic [DATA_WIDTH-1:0] rd_in,
    input  wire logic [DATA_WIDTH-1:0] right_in,
    output pol_pkg::tok_t              tok_out,
    output logic [DATA_WIDTH-1:0]      carry_out,
    output logic [DATA_WIDTH-1:0]      rd_out,
    output logic [DATA_WIDTH-1:0]      entry_out
);

    import pol_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    tok_t                  tok_reg;
    tok_t                  tok_next;
    logic [DATA_WIDTH-1:0] carry_reg;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic [DATA_WIDTH-1:0] rd_next;
    logic                  hit;
    logic                  after;

    assign hit   = (32'(cmd.pos) == 32'(IDX + 1));
    assign after = (32'(cmd.pos) <= 32'(IDX));

    always_comb
    begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        rd_next    = rd_in;
        case (cmd.op)
            OP_INSERT:
            begin
                if (hit)
                begin
                    entry_next = val;
                end
                else if (after)
                begin
                    entry_next = carry_in;
                end
            end
            OP_DELETE:
            begin
                if (hit || after)
                begin
                    entry_next = right_in;
                end
                if (hit)
                begin
                    rd_next = entry_reg;
                end
            end
            OP_READ:
            begin
                if (hit)
                begin
                    rd_next = entry_reg;
                end
            end
            OP_LOCATE:
            begin
                if (!tok_in.hit && (32'(len) > 32'(IDX)) && (entry_reg == val))
                begin
                    tok_next.hit   = 1'b1;
                    tok_next.found = COUNT_W'(IDX + 1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg.valid <= tok_in.valid;
            if (tok_in.valid)
            begin
                tok_reg.hit   <= tok_next.hit;
                tok_reg.found <= tok_next.found;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            entry_reg <= entry_next;
            carry_reg <= entry_reg;
            rd_reg    <= rd_next;
        end
    end

    assign tok_out   = tok_reg;
    assign carry_out = carry_reg;
    assign rd_out    = rd_reg;
    assign entry_out = entry_reg;

endmodule

`default_nettype wire

[rtl/core/positional_ordered_list.sv]
// channel   direction  beat fields (low bit first)
// s_axis    in         tuser: kind[2:0]; tdata: position[4:0] value[36:5]
// m_axis    out        tdata: status[0] read_value[32:1] found_position[37:33] count[42:38]
//
// Each request walks the cell chain one cell per cycle; the next request is
// taken only once the previous result has moved from the result register
// into the output register.
// Reset clears the length and all control; entries hold garbage until written.
// A stalled result waits in the output register while the next request runs.
`default_nettype none

module positional_ordered_list #(
    parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // position, value, zero pad
    input  wire logic [pol_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // kind
    input  wire logic [pol_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // status, read_value, found_position, count, zero pad
    output logic [pol_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    import pol_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);

    logic [KIND_W-1:0]     kind_in;
    logic [POS_W-1:0]      pos_in;
    logic [63:0]           value_ext;
    logic [DATA_WIDTH-1:0] val_in;

    logic                  in_fire;
    logic                  busy_reg;
    logic                  start_reg;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [LEN_W-1:0]      length_reg;
    logic [LEN_W-1:0]      length_next;
    logic                  status_reg;
    logic                  status_next;

    logic                  res_valid_reg;
    logic [OUT_TDATA_W-1:0] res_reg;
    logic                  res_move;
    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic [31:0]           p32;
    logic [31:0]           l32;
    logic [63:0]           rd_ext;

    tok_t                  tok   [0:CAPACITY];
    logic [DATA_WIDTH-1:0] carry [0:CAPACITY];
    logic [DATA_WIDTH-1:0] rd    [0:CAPACITY];
    logic [DATA_WIDTH-1:0] entry [0:CAPACITY-1];

    assign kind_in   = s_axis_tuser;
    assign pos_in    = s_axis_tdata[4:0];
    assign value_ext = {32'b0, s_axis_tdata[36:5]};
    assign val_in    = value_ext[DATA_WIDTH-1:0];

    assign s_axis_tready = !busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign p32 = 32'(pos_in);
    assign l32 = 32'(length_reg);

    always_comb
    begin
        cmd_next.pos = pos_in;
        cmd_next.op  = OP_NONE;
        status_next  = 1'b0;
        length_next  = length_reg;
        unique case (kind_in)
            KIND_INSERT:
            begin
                if ((l32 >= 32'(CAPACITY)) || (p32 < 32'd1) || (p32 > l32 + 32'd1))
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    cmd_next.op = OP_INSERT;
                    length_next = LEN_W'(l32 + 32'd1);
                end
            end
            KIND_DELETE:
            begin
                if ((p32 < 32'd1) || (p32 > l32))
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    cmd_next.op = OP_DELETE;
                    length_next = LEN_W'(l32 - 32'd1);
                end
            end
            KIND_GET:
            begin
                if ((p32 < 32'd1) || (p32 > l32))
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    cmd_next.op = OP_READ;
                end
            end
            KIND_LOCATE:
            begin
                cmd_next.op = OP_LOCATE;
            end
            KIND_CLEAR:
            begin
                length_next = '0;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    assign tok[0]   = '{valid: start_reg, hit: 1'b0, found: '0};
    assign carry[0] = '0;
    assign rd[0]    = '0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] right;
        if (k == CAPACITY - 1)
        begin : g_last
            assign right = entry[k];
        end
        else
        begin : g_mid
            assign right = entry[k + 1];
        end

        pol_cell #(
            .IDX        (k),
            .DATA_WIDTH (DATA_WIDTH),
            .LEN_W      (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd_reg),
            .len       (length_reg),
            .val       (val_reg),
            .tok_in    (tok[k]),
            .carry_in  (carry[k]),
            .rd_in     (rd[k]),
            .right_in  (right),
            .tok_out   (tok[k + 1]),
            .carry_out (carry[k + 1]),
            .rd_out    (rd[k + 1]),
            .entry_out (entry[k])
        );
    end

    assign rd_ext   = 64'(rd[CAPACITY]);
    assign res_move = res_valid_reg && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            cmd_reg       <= '{op: OP_NONE, pos: '0};
            length_reg    <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= in_fire;
            if (in_fire)
            begin
                busy_reg   <= 1'b1;
                cmd_reg    <= cmd_next;
                length_reg <= length_next;
            end
            else if (res_move)
            begin
                busy_reg <= 1'b0;
            end

            if (tok[CAPACITY].valid)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_move)
            begin
                res_valid_reg <= 1'b0;
            end

            if (res_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            val_reg    <= val_in;
            status_reg <= status_next;
        end
        if (tok[CAPACITY].valid)
        begin
            res_reg <= {5'b0, COUNT_W'(length_reg), tok[CAPACITY].found,
                        rd_ext[VALUE_W-1:0], status_reg};
        end
        if (res_move)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> busy_reg)
        else $error("chain started while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy_reg && start_reg)
        else $error("accepted beat did not launch");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok[CAPACITY].valid |-> busy_reg && !res_valid_reg)
        else $error("result arrived with result slot full");

    a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(length_reg) <= 32'(CAPACITY))
        else $error("length above capacity");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !res_valid_reg && !tok[CAPACITY].valid)
        else $error("chain active while idle");

endmodule

`default_nettype wire

[verif/positional_ordered_list_tb.sv]
`timescale 1ns / 1ps

module positional_ordered_list_tb;

    import pol_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1925;
    localparam int TAIL_ITEMS   = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = CAPACITY + 24;

    typedef struct packed {
        logic               status;
        logic [31:0]        read_value;
        logic [POS_W-1:0]   found;
        logic [COUNT_W-1:0] count;
    } reply_t;

    class list_tracker;
        logic [31:0] slots [CAPACITY];
        int          fill;
        reply_t      pending_replies [$];
        int          mismatch_count;

        function new();
            fill = 0;
            mismatch_count = 0;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                   logic [31:0] value);
            reply_t want;
            int     p;
            want = '0;
            p = pos;
            case (kind)
                KIND_INSERT:
                    if (fill >= CAPACITY || p < 1 || p > fill + 1)
                        want.status = 1'b1;
                    else
                    begin
                        for (int k = fill; k >= p; k--)
                            slots[k] = slots[k-1];
                        slots[p-1] = value;
                        fill++;
                    end
                KIND_DELETE:
                    if (p < 1 || p > fill)
                        want.status = 1'b1;
                    else
                    begin
                        want.read_value = slots[p-1];
                        for (int k = p; k < fill; k++)
                            slots[k-1] = slots[k];
                        fill--;
                    end
                KIND_GET:
                    if (p < 1 || p > fill)
                        want.status = 1'b1;
                    else
                        want.read_value = slots[p-1];
                KIND_LOCATE:
                    for (int k = 0; k < fill; k++)
                    begin
                        if (slots[k] == value)
                        begin
                            want.found = POS_W'(k + 1);
                            break;
                        end
                    end
                KIND_CLEAR:
                    fill = 0;
                default:
                    want.status = 1'b1;
            endcase
            want.count = COUNT_W'(fill);
            pending_replies.push_back(want);
        endfunction

        function void check_reply(logic [OUT_TDATA_W-1:0] beat);
            reply_t got;
            reply_t want;
            got.status     = beat[0];
            got.read_value = beat[32:1];
            got.found      = beat[37:33];
            got.count      = beat[42:38];
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply: status %0d read %h found %0d count %0d",
                             got.status, got.read_value, got.found, got.count);
                return;
            end
            want = pending_replies.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t mismatch: status %0d/%0d read %h/%h found %0d/%0d count %0d/%0d",
                             $time, want.status, got.status, want.read_value, got.read_value,
                             want.found, got.found, want.count, got.count);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    list_tracker tracker = new();
    int          accepted_requests = 0;
    int          send_idle_pct = 25;
    int          recv_stall_pct = 5;
    bit          quiet_tail = 1'b0;
    bit          held_off = 1'b0;

    positional_ordered_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.note_request(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[36:5]);
                accepted_requests++;
            end
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_reply(m_axis_tdata);
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && accepted_requests >= 300)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < recv_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic push_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                logic [31:0] value);
        if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b0, value, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position(bit for_insert);
        int limit;
        int r;
        limit = for_insert ? tracker.fill + 1 : tracker.fill;
        r = $urandom_range(0, 99);
        if (r < 80 && limit > 0)
            return POS_W'($urandom_range(1, limit));
        else if (r < 90)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return POS_W'(limit + 1);
                default: return POS_W'(limit);
            endcase
        end
        return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        else if (r < 65 && tracker.fill > 0)
            return tracker.slots[$urandom_range(0, tracker.fill - 1)];
        else if (r < 80)
            return 32'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic random_request(bit growing);
        logic [KIND_W-1:0] kind;
        int                r;
        r = $urandom_range(0, 99);
        if (growing)
            kind = r < 58 ? KIND_INSERT : r < 68 ? KIND_DELETE : r < 81 ? KIND_GET :
                   r < 95 ? KIND_LOCATE : r < 96 ? KIND_CLEAR : KIND_W'($urandom_range(5, 7));
        else
            kind = r < 15 ? KIND_INSERT : r < 58 ? KIND_DELETE : r < 74 ? KIND_GET :
                   r < 95 ? KIND_LOCATE : r < 96 ? KIND_CLEAR : KIND_W'($urandom_range(5, 7));
        push_request(kind, pick_position(kind == KIND_INSERT), pick_value());
    endtask

    initial
    begin
        int       pcts [3];
        bit       growing;
        int       pos;
        logic [31:0] v;
        pcts = '{0, 20, 50};
        growing = 1'b1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        push_request(KIND_GET, 5'd1, 32'h0);
        push_request(KIND_INSERT, 5'd0, 32'h1234_5678);
        push_request(KIND_INSERT, 5'd2, 32'h1234_5678);
        for (int i = 0; i < CAPACITY; i++)
        begin
            pos = (i % 3 == 0) ? 1 : (i % 3 == 1) ? i + 1 : i / 2 + 1;
            case (i)
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'h0000_0000;
                3:       v = 32'hffff_ffff;
                4, 9:    v = 32'd5;
                default: v = $urandom;
            endcase
            push_request(KIND_INSERT, POS_W'(pos), v);
        end
        push_request(KIND_INSERT, 5'd1, 32'h0bad_0bad);
        push_request(KIND_LOCATE, 5'd0, 32'd5);
        push_request(KIND_LOCATE, 5'd31, 32'h1357_9bdf);
        push_request(KIND_GET, 5'd16, 32'h0);
        push_request(KIND_GET, 5'd17, 32'h0);
        push_request(KIND_DELETE, 5'd31, 32'h0);
        push_request(KIND_DELETE, 5'd16, 32'h0);
        push_request(KIND_DELETE, 5'd1, 32'hffff_ffff);
        push_request(3'd7, 5'd1, 32'h0);
        push_request(KIND_CLEAR, 5'd0, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                send_idle_pct = pcts[$urandom_range(0, 2)];
                recv_stall_pct = pcts[$urandom_range(0, 2)] / 4;
            end
            if (n % 40 == 0)
                growing = ($urandom_range(0, 99) < 60);
            quiet_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
            random_request(growing);
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
